// File: sv/pwcg_pkg.sv
// Package for the pulse window command generator.
// Holds the item structs, request, status and register codes, and time constants.
// No dependencies.
package pwcg_pkg;

	typedef enum logic [2:0] {
		REQ_TICK   = 3'd0,
		REQ_LOAD   = 3'd1,
		REQ_MANUAL = 3'd2,
		REQ_STOP   = 3'd3,
		REQ_STATE  = 3'd4
	} req_e;

	typedef enum logic [2:0] {
		STAT_OK            = 3'd0,
		STAT_UNKNOWN_GYRO  = 3'd1,
		STAT_LOAD_REFUSED  = 3'd2,
		STAT_MANUAL_MODE   = 3'd3,
		STAT_MANUAL_STATE  = 3'd4
	} status_e;

	typedef enum logic [2:0] {
		REG_POWER_DELAY = 3'd0,
		REG_START_EVENT = 3'd1,
		REG_STOP_EVENT  = 3'd2,
		REG_RUN_LENGTH  = 3'd3,
		REG_POWER_ON    = 3'd4,
		REG_POWER_OFF   = 3'd5,
		REG_OFFLINE     = 3'd6,
		REG_ONLINE_OFF  = 3'd7
	} cfg_reg_e;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	// Pulse length scale factors in microseconds
	localparam logic [32:0] US_PER_MS  = 33'd1000;
	localparam logic [32:0] US_PER_S   = 33'd1000000;
	localparam logic [32:0] US_PER_MIN = 33'd60000000;

	localparam logic [7:0] TRIGGER_SET   = 8'd1;
	localparam logic [7:0] GYRO_FIRST    = 8'd0;
	localparam logic [7:0] GYRO_SECOND   = 8'd1;
	localparam logic [7:0] MODE_MANUAL   = 8'd1;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now_us;
		logic [7:0]  trigger;
		logic [7:0]  run_state;
		logic [9:0]  pulse_ms;
		logic [5:0]  pulse_s;
		logic [6:0]  pulse_min;
		logic [7:0]  gyrotron_pick;
		logic [7:0]  mode_pick;
	} in_item_t;

	typedef struct packed {
		logic [7:0] event_out;
		logic [7:0] command_out;
		logic [2:0] status;
	} out_item_t;

	typedef struct packed {
		logic [31:0] power_delay_us;
		logic [7:0]  start_event_code;
		logic [7:0]  stop_event_code;
		logic [31:0] run_length_us;
		logic [7:0]  power_on_code;
		logic [7:0]  power_off_code;
		logic [7:0]  offline_code;
		logic [7:0]  online_off_code;
	} cfg_t;

	// Item after the input register: pulse length already scaled
	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now_us;
		logic        triggered;
		logic [7:0]  run_state;
		logic [32:0] pulse_us;
		logic        gyro_first;
		logic        gyro_unknown;
		logic        mode_manual;
	} s1_item_t;

endpackage

// File: sv/pwcg_cfg_regs.sv
// Configuration register bank of the pulse window command generator.
// Depends on pwcg_pkg.
module pwcg_cfg_regs import pwcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_POWER_DELAY: cfg_q.power_delay_us   <= cfg_wdata;
				REG_START_EVENT: cfg_q.start_event_code <= cfg_wdata[7:0];
				REG_STOP_EVENT:  cfg_q.stop_event_code  <= cfg_wdata[7:0];
				REG_RUN_LENGTH:  cfg_q.run_length_us    <= cfg_wdata;
				REG_POWER_ON:    cfg_q.power_on_code    <= cfg_wdata[7:0];
				REG_POWER_OFF:   cfg_q.power_off_code   <= cfg_wdata[7:0];
				REG_OFFLINE:     cfg_q.offline_code     <= cfg_wdata[7:0];
				REG_ONLINE_OFF:  cfg_q.online_off_code  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: sv/pwcg_in_stage.sv
// Input register stage: takes an item, decodes the picks and scales the pulse length.
// Depends on pwcg_pkg.
module pwcg_in_stage import pwcg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     take,
	output logic     s1_valid,
	output s1_item_t s1_item
);

	logic     valid_s1;
	s1_item_t item_s1;
	s1_item_t item_d;

	always_comb begin
		item_d.req_type     = in_item.req_type;
		item_d.now_us       = in_item.now_us;
		item_d.triggered    = (in_item.trigger == TRIGGER_SET);
		item_d.run_state    = in_item.run_state;
		item_d.gyro_first   = (in_item.gyrotron_pick == GYRO_FIRST);
		item_d.gyro_unknown = (in_item.gyrotron_pick > GYRO_SECOND);
		item_d.mode_manual  = (in_item.mode_pick == MODE_MANUAL);
		// Constant multiplies only; the sum of the three terms fits 33 bits
		item_d.pulse_us = (33'(in_item.pulse_ms) + 33'd1) * US_PER_MS
			+ 33'(in_item.pulse_s) * US_PER_S
			+ 33'(in_item.pulse_min) * US_PER_MIN;
	end

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item_d;
		end
	end

	assign s1_valid = valid_s1;
	assign s1_item  = item_s1;

endmodule

// File: sv/pwcg_ctrl.sv
// Request handling, window state and result register.
// Depends on pwcg_pkg.
module pwcg_ctrl import pwcg_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      s1_valid,
	input  s1_item_t  s1_item,
	output logic      take,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	logic        load_pending_q, load_pending_d;
	logic        manual_mode_q, manual_mode_d;
	logic        gyro_first_q, gyro_first_d;
	logic [33:0] total_q, total_d;
	logic [31:0] req_time_q, req_time_d;
	logic        disarmed_q, disarmed_d;
	logic [32:0] deadline_q, deadline_d;

	logic        out_valid_q;
	out_item_t   out_q, res_d;

	logic        have_rel;
	logic [31:0] rel;
	logic [32:0] deadline_now;
	logic        in_window;
	logic [7:0]  ev;

	assign take = s1_valid && (!out_valid_q || out_ready);

	always_comb begin
		load_pending_d = load_pending_q;
		manual_mode_d  = manual_mode_q;
		gyro_first_d   = gyro_first_q;
		total_d        = total_q;
		req_time_d     = req_time_q;
		disarmed_d     = disarmed_q;
		deadline_d     = deadline_q;
		res_d          = '0;

		have_rel = !disarmed_q && (s1_item.now_us > req_time_q);
		rel      = s1_item.now_us - req_time_q;

		// Latch the deadline on the first triggered tick
		deadline_now = deadline_q;
		if (s1_item.triggered && deadline_q == '0) begin
			deadline_now = {1'b0, s1_item.now_us} + {1'b0, cfg.run_length_us};
		end
		in_window = s1_item.triggered && ({1'b0, s1_item.now_us} < deadline_now);
		ev = in_window ? cfg.start_event_code : cfg.stop_event_code;

		unique case (s1_item.req_type)
			REQ_TICK: begin
				load_pending_d    = 1'b0;
				deadline_d        = deadline_now;
				res_d.event_out   = ev;
				res_d.command_out = cfg.power_off_code;
				// Equal start and stop codes open the power logic outside the window too
				if (ev == cfg.start_event_code) begin
					if (!gyro_first_q || (have_rel && rel > cfg.power_delay_us
							&& {2'b0, rel} <= total_q)) begin
						res_d.command_out = cfg.power_on_code;
					end
				end
				if (load_pending_q) begin
					if (s1_item.run_state == cfg.offline_code) begin
						manual_mode_d = s1_item.mode_manual;
						gyro_first_d  = s1_item.gyro_first;
						total_d       = {2'b0, cfg.power_delay_us} + {1'b0, s1_item.pulse_us};
						if (s1_item.gyro_unknown) begin
							res_d.status = STAT_UNKNOWN_GYRO;
						end
					end else begin
						res_d.status = STAT_LOAD_REFUSED;
					end
				end
			end
			REQ_LOAD: begin
				load_pending_d = 1'b1;
			end
			REQ_MANUAL: begin
				if (!manual_mode_q) begin
					res_d.status = STAT_MANUAL_MODE;
				end else if (s1_item.run_state != cfg.online_off_code) begin
					res_d.status = STAT_MANUAL_STATE;
				end else begin
					req_time_d = s1_item.now_us;
					disarmed_d = 1'b0;
				end
			end
			REQ_STOP: begin
				disarmed_d = 1'b1;
			end
			REQ_STATE: begin
				if (manual_mode_q) begin
					disarmed_d = 1'b1;
				end else begin
					req_time_d = '0;
					disarmed_d = 1'b0;
				end
				deadline_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pending_q <= 1'b0;
			manual_mode_q  <= 1'b0;
			gyro_first_q   <= 1'b1;
			total_q        <= '0;
			req_time_q     <= '0;
			disarmed_q     <= 1'b0;
			deadline_q     <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (take) begin
				load_pending_q <= load_pending_d;
				manual_mode_q  <= manual_mode_d;
				gyro_first_q   <= gyro_first_d;
				total_q        <= total_d;
				req_time_q     <= req_time_d;
				disarmed_q     <= disarmed_d;
				deadline_q     <= deadline_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

`ifndef SYNTH
	a_take_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("result register not loaded after an item was taken");

	a_non_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(take && s1_item.req_type != REQ_TICK) |=>
			(out_q.event_out == '0 && out_q.command_out == '0))
		else $error("non-tick item produced event or command code");

	a_tick_clears_load: assert property (@(posedge clk) disable iff (!arst_n)
		(take && s1_item.req_type == REQ_TICK) |=> !load_pending_q)
		else $error("pending load survived a tick");

	a_deadline_latch_once: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(deadline_q) && $past(deadline_q) != '0) |-> deadline_q == '0)
		else $error("latched deadline changed without being cleared");
`endif

endmodule

// File: sv/pulse_window_command_gen.sv
// Top level of the pulse window command generator.
// Depends on pwcg_pkg, pwcg_cfg_regs, pwcg_in_stage and pwcg_ctrl.
//
// Each item gives exactly one result. It passes first through the input
// register, where the pulse length is scaled to microseconds, and then the
// result register, loaded by the request logic that also updates the window
// state. One item is taken per clock cycle as long as out_ready is high; a
// stalled result holds in the result register while the input register, if
// empty, still takes one more item. Configuration registers are written through
// cfg_we/cfg_addr/cfg_wdata and should only change while no item is in flight.
module pulse_window_command_gen_core import pwcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item
);

	cfg_t     cfg;
	logic     s1_valid;
	s1_item_t s1_item;
	logic     take;

	pwcg_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	pwcg_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.s1_valid (s1_valid),
		.s1_item  (s1_item)
	);

	pwcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s1_valid  (s1_valid),
		.s1_item   (s1_item),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
